// File: hw/rtl/affine_point_normal_transform_top_assert.svh
// assertion macros for the affine point/normal transform block
`ifndef AFFINE_POINT_NORMAL_TRANSFORM_TOP_ASSERT_SVH
`define AFFINE_POINT_NORMAL_TRANSFORM_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define APNT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define APNT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/apnt_pkg.sv
// shared types and constants for the affine point/normal transform
package apnt_pkg;

	localparam int NUM_ROWS = 3;
	localparam int NUM_REGS = 6;
	localparam int ADDR_W   = 6;
	localparam int DATA_W   = 64;
	localparam int ELEM_W   = 32;
	localparam int PROD_W   = 64;
	localparam int ACC_W    = 66;
	localparam int IDX_W    = 3;

	localparam logic [ELEM_W-1:0] SAT_MAX = 32'h7fff_ffff;
	localparam logic [ELEM_W-1:0] SAT_MIN = 32'h8000_0000;

	localparam logic [DATA_W-1:0] REG_RESET [NUM_REGS] = '{
		64'h0000_0001_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0001_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0001_0000
	};

	// one matrix row: three linear coefficients and the translation
	typedef struct packed {
		logic signed [ELEM_W-1:0] m0;
		logic signed [ELEM_W-1:0] m1;
		logic signed [ELEM_W-1:0] m2;
		logic signed [ELEM_W-1:0] m3;
	} row_coef_t;

	// per-stage load strobes
	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
	} pipe_ld_t;

endpackage

// File: hw/rtl/apnt_cfg.sv
// matrix register file behind the apb-style configuration port
module apnt_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [apnt_pkg::ADDR_W-1:0]     paddr,
	input  logic [apnt_pkg::DATA_W-1:0]     pwdata,
	output logic [apnt_pkg::DATA_W-1:0]     prdata,
	output logic                            pready,
	output apnt_pkg::row_coef_t             row_coef [apnt_pkg::NUM_ROWS]
);
	import apnt_pkg::*;

	logic [DATA_W-1:0] cfg_q [NUM_REGS];
	logic [IDX_W-1:0]  reg_idx;
	logic              idx_ok;
	logic              wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:ADDR_W-IDX_W];
	assign idx_ok  = (reg_idx < IDX_W'(NUM_REGS));
	assign wr_en   = psel && penable && pwrite && pready && idx_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				cfg_q[i] <= REG_RESET[i];
			end
		end else if (wr_en) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				if (reg_idx == IDX_W'(i)) begin
					cfg_q[i] <= pwdata;
				end
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (idx_ok) begin
			prdata = cfg_q[reg_idx];
		end
	end

	// even register: m0 low, m1 high; odd register: m2 low, translation high
	for (genvar j = 0; j < NUM_ROWS; j++) begin : g_row
		assign row_coef[j].m0 = cfg_q[2*j][ELEM_W-1:0];
		assign row_coef[j].m1 = cfg_q[2*j][DATA_W-1:ELEM_W];
		assign row_coef[j].m2 = cfg_q[2*j+1][ELEM_W-1:0];
		assign row_coef[j].m3 = cfg_q[2*j+1][DATA_W-1:ELEM_W];
	end

endmodule

// File: hw/rtl/apnt_pipe_ctrl.sv
// valid bits and load strobes for the four-stage pipeline
`include "affine_point_normal_transform_top_assert.svh"

module apnt_pipe_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	output apnt_pkg::pipe_ld_t   pipe_ld
);
	import apnt_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic en1, en2, en3, en4;

	// a stage may load when it is empty or its content moves on
	assign en4 = !vld_s4 || !out_stall;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;

	assign in_stall  = !en1;
	assign out_valid = vld_s4;

	assign pipe_ld.ld_s1 = en1 && in_valid;
	assign pipe_ld.ld_s2 = en2 && vld_s1;
	assign pipe_ld.ld_s3 = en3 && vld_s2;
	assign pipe_ld.ld_s4 = en4 && vld_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= in_valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
		end
	end

	`APNT_ASSERT_NOW(a_stall_needs_full_s1, in_stall, vld_s1, "input stalled with stage 1 empty")
	`APNT_ASSERT_NEXT(a_request_lands_s1, in_valid && !in_stall, vld_s1, "accepted request lost")
	`APNT_ASSERT_NEXT(a_s1_held, vld_s1 && in_stall, vld_s1, "held stage 1 request dropped")
	`APNT_ASSERT_NEXT(a_bubble_fills, vld_s3 && !vld_s4, vld_s4, "empty output stage not filled")

endmodule

// File: hw/rtl/apnt_row.sv
// one matrix row: multiply, sum, round and saturate over four stages
module apnt_row #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                clk,
	input  apnt_pkg::row_coef_t                 coef,
	input  logic                                kind,
	input  logic signed [apnt_pkg::ELEM_W-1:0]  vec_x,
	input  logic signed [apnt_pkg::ELEM_W-1:0]  vec_y,
	input  logic signed [apnt_pkg::ELEM_W-1:0]  vec_z,
	input  apnt_pkg::pipe_ld_t                  pipe_ld,
	output logic [apnt_pkg::ELEM_W-1:0]         res,
	output logic                                sat
);
	import apnt_pkg::*;

	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);

	logic signed [PROD_W-1:0] prod0_s1, prod1_s1, prod2_s1;
	logic signed [ACC_W-1:0]  trans_s1;
	logic signed [ACC_W-1:0]  sum01_s2, sum2t_s2;
	logic signed [ACC_W-1:0]  acc_s3;
	logic [ELEM_W-1:0]        res_s4;
	logic                     sat_s4;

	logic signed [ACC_W-1:0]  trans_full;
	logic signed [ACC_W-1:0]  shifted;
	logic                     fits;

	// translation scaled by one in fixed point, only for points
	assign trans_full = (!kind) ? (ACC_W'(coef.m3) <<< FRAC_BITS) : '0;

	always_ff @(posedge clk) begin
		if (pipe_ld.ld_s1) begin
			prod0_s1 <= coef.m0 * vec_x;
			prod1_s1 <= coef.m1 * vec_y;
			prod2_s1 <= coef.m2 * vec_z;
			trans_s1 <= trans_full;
		end
		if (pipe_ld.ld_s2) begin
			sum01_s2 <= ACC_W'(prod0_s1) + ACC_W'(prod1_s1);
			sum2t_s2 <= ACC_W'(prod2_s1) + trans_s1;
		end
		if (pipe_ld.ld_s3) begin
			acc_s3 <= sum01_s2 + sum2t_s2 + HALF;
		end
		if (pipe_ld.ld_s4) begin
			res_s4 <= fits ? shifted[ELEM_W-1:0] : (shifted[ACC_W-1] ? SAT_MIN : SAT_MAX);
			sat_s4 <= !fits;
		end
	end

	assign shifted = acc_s3 >>> FRAC_BITS;
	// in range when the result's sign bit and every bit above it copy the sign
	assign fits = (shifted[ACC_W-1:ELEM_W-1] == {(ACC_W-ELEM_W+1){shifted[ACC_W-1]}});

	assign res = res_s4;
	assign sat = sat_s4;

endmodule

// File: hw/rtl/affine_point_normal_transform_top.sv
// affine 3x4 transform top: register file, pipeline control, three row datapaths
// a request accepted into stage 1 passes stages 2 and 3 and is on the output from stage 4's registers
// throughput: one request per cycle unless stalled, set by the four-stage pipeline, one multiplier per product
// stalls hold the pipeline in place; empty stages keep filling while the output waits
// reset clears all valid bits and loads the matrix registers with their defaults
module affine_point_normal_transform_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [apnt_pkg::ADDR_W-1:0]         paddr,
	input  logic [apnt_pkg::DATA_W-1:0]         pwdata,
	output logic [apnt_pkg::DATA_W-1:0]         prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                kind,
	input  logic signed [apnt_pkg::ELEM_W-1:0]  vec_x,
	input  logic signed [apnt_pkg::ELEM_W-1:0]  vec_y,
	input  logic signed [apnt_pkg::ELEM_W-1:0]  vec_z,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [apnt_pkg::ELEM_W-1:0]  res_x,
	output logic signed [apnt_pkg::ELEM_W-1:0]  res_y,
	output logic signed [apnt_pkg::ELEM_W-1:0]  res_z,
	output logic                                overflow
);
	import apnt_pkg::*;

	row_coef_t         row_coef [NUM_ROWS];
	pipe_ld_t          pipe_ld;
	logic [ELEM_W-1:0] row_res  [NUM_ROWS];
	logic [NUM_ROWS-1:0] row_sat;

	apnt_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.row_coef (row_coef)
	);

	apnt_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pipe_ld   (pipe_ld)
	);

	for (genvar j = 0; j < NUM_ROWS; j++) begin : g_row
		apnt_row #(
			.FRAC_BITS (FRAC_BITS)
		) u_row (
			.clk     (clk),
			.coef    (row_coef[j]),
			.kind    (kind),
			.vec_x   (vec_x),
			.vec_y   (vec_y),
			.vec_z   (vec_z),
			.pipe_ld (pipe_ld),
			.res     (row_res[j]),
			.sat     (row_sat[j])
		);
	end

	assign res_x    = row_res[0];
	assign res_y    = row_res[1];
	assign res_z    = row_res[2];
	assign overflow = |row_sat;

endmodule
